// ===== rtl/core/bis_pkg.sv =====
// Shared types, constants and arithmetic helpers for the bicubic image scaler.
`timescale 1ns / 1ps

package bis_pkg;

  // Pixel store geometry.
  localparam int unsigned MAX_SRC_HEIGHT = 256;
  localparam int unsigned MAX_SRC_WIDTH  = 256;
  localparam int unsigned ROW_BITS       = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned COL_BITS       = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned ADDR_BITS      = ROW_BITS + COL_BITS;
  localparam int unsigned PIX_BITS       = 24;

  // Datapath widths.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ACC_BITS  = 36;
  localparam int unsigned DVD_BITS  = 25;
  localparam int unsigned DVS_BITS  = 12;
  localparam int unsigned BASE_BITS = 22;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SRC_HEIGHT = 2'd0,
    REG_SRC_WIDTH  = 2'd1,
    REG_DST_HEIGHT = 2'd2,
    REG_DST_WIDTH  = 2'd3
  } reg_idx_t;

  // Input commands.
  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_REQUEST = 1'b1
  } cmd_t;

  // Top level sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL,
    ST_POS,
    ST_FETCH,
    ST_CUB_GO,
    ST_CUB_WAIT
  } state_t;

  // Cubic unit states.
  typedef enum logic [1:0] {
    CU_IDLE,
    CU_COEF,
    CU_MUL,
    CU_ADD
  } cub_state_t;

  // Round a signed value right by s bits, to nearest with ties to even.
  function automatic logic signed [63:0] rne(input logic signed [63:0] v,
                                             input logic [4:0] s);
    logic        neg;
    logic [63:0] m;
    logic [63:0] half;
    logic [63:0] q;
    logic [63:0] r;
    neg  = v[63];
    m    = neg ? (64'd0 - 64'(v)) : 64'(v);
    half = 64'd1 << (s - 5'd1);
    q    = m >> s;
    r    = m & ((half << 1) - 64'd1);
    if ((r > half) || ((r == half) && q[0])) begin
      q = q + 64'd1;
    end
    return neg ? $signed(64'd0 - q) : $signed(q);
  endfunction

  // Neighbour index base+k-1, reflected at the borders then clamped into 0..n-1.
  function automatic logic [7:0] border(input logic [BASE_BITS-1:0] base,
                                        input logic [1:0] k,
                                        input logic [8:0] n);
    logic signed [24:0] i;
    logic signed [24:0] ns;
    ns = $signed({16'd0, n});
    i  = $signed({3'd0, base}) + $signed({23'd0, k}) - 25'sd1;
    if (i < 0) begin
      i = -25'sd1 - i;
    end
    if (i >= ns) begin
      i = 2 * ns - 25'sd1 - i;
    end
    if (i < 0) begin
      i = 25'sd0;
    end
    if (i >= ns) begin
      i = ns - 25'sd1;
    end
    return i[7:0];
  endfunction

endpackage

// ===== rtl/core/bis_store.sv =====
// Single-port source pixel store with registered read data.
`timescale 1ns / 1ps

module bis_store (
  input  logic                              clk,
  input  logic                              we,
  input  logic [bis_pkg::ADDR_BITS-1:0]     addr,
  input  logic [bis_pkg::PIX_BITS-1:0]      wdata,
  output logic [bis_pkg::PIX_BITS-1:0]      rdata
);

  logic [bis_pkg::PIX_BITS-1:0] mem [2**bis_pkg::ADDR_BITS];

  // One access per cycle: a write, or a read whose data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/bis_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bis_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bis_pkg::DVD_BITS-1:0]  dividend,
  input  logic [bis_pkg::DVS_BITS-1:0]  divisor,
  output logic                          done,
  output logic [bis_pkg::DVD_BITS-1:0]  quotient
);

  localparam int unsigned CNT_BITS = $clog2(bis_pkg::DVD_BITS);

  logic                         running;
  logic [CNT_BITS-1:0]          cnt;
  logic [bis_pkg::DVS_BITS-1:0] rem;
  logic [bis_pkg::DVS_BITS:0]   rem_sh;
  logic                         fits;

  // Trial subtraction of the shifted partial remainder.
  assign rem_sh = {rem, quotient[bis_pkg::DVD_BITS-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        quotient <= dividend;
      end else if (running) begin
        rem      <= fits ? bis_pkg::DVS_BITS'(rem_sh - {1'b0, divisor})
                         : bis_pkg::DVS_BITS'(rem_sh);
        quotient <= {quotient[bis_pkg::DVD_BITS-2:0], fits};
        if (cnt == CNT_BITS'(bis_pkg::DVD_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/bis_cubic.sv =====
// Catmull-Rom evaluator: Horner's scheme over one shared multiplier.
`timescale 1ns / 1ps

module bis_cubic (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [bis_pkg::ACC_BITS-1:0]  f [4],
  input  logic [bis_pkg::FRAC_BITS-1:0]        t,
  output logic                                 done,
  output logic signed [bis_pkg::ACC_BITS-1:0]  res
);

  localparam int unsigned PROD_BITS = bis_pkg::ACC_BITS + bis_pkg::FRAC_BITS + 1;

  bis_pkg::cub_state_t state, state_next;

  logic signed [bis_pkg::ACC_BITS-1:0]  fr [4];
  logic [bis_pkg::FRAC_BITS-1:0]        tr;
  logic signed [bis_pkg::ACC_BITS-1:0]  b2, c2, d2;
  logic signed [PROD_BITS-1:0]          prod;
  logic [1:0]                           step;
  logic signed [63:0]                   prod_rnd;
  logic signed [bis_pkg::ACC_BITS-1:0]  addend;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bis_pkg::CU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bis_pkg::CU_IDLE: if (start) state_next = bis_pkg::CU_COEF;
      bis_pkg::CU_COEF: state_next = bis_pkg::CU_MUL;
      bis_pkg::CU_MUL:  state_next = bis_pkg::CU_ADD;
      bis_pkg::CU_ADD:  if (step == 2'd2) state_next = bis_pkg::CU_IDLE;
                        else state_next = bis_pkg::CU_MUL;
      default:          state_next = bis_pkg::CU_IDLE;
    endcase
  end

  // Product rounded back to Q16, plus the coefficient of this Horner step.
  assign prod_rnd = bis_pkg::rne(64'(prod), 5'(bis_pkg::FRAC_BITS));
  always_comb begin
    unique case (step)
      2'd0:    addend = b2;
      2'd1:    addend = c2;
      default: addend = d2;
    endcase
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        bis_pkg::CU_IDLE: begin
          if (start) begin
            fr <= f;
            tr <= t;
          end
        end
        bis_pkg::CU_COEF: begin
          res  <= -fr[0] + 3 * fr[1] - 3 * fr[2] + fr[3];
          b2   <= 2 * fr[0] - 5 * fr[1] + 4 * fr[2] - fr[3];
          c2   <= fr[2] - fr[0];
          d2   <= 2 * fr[1];
          step <= '0;
        end
        bis_pkg::CU_MUL: begin
          prod <= PROD_BITS'(res) * $signed({1'b0, tr});
        end
        bis_pkg::CU_ADD: begin
          res <= prod_rnd[bis_pkg::ACC_BITS-1:0] + addend;
          if (step == 2'd2) begin
            done <= 1'b1;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/bicubic_image_scaler_top.sv =====
// Top level of the bicubic image scaler: configuration, sequencer and mapping.
//
//  Channel  | Handshake                        | Payload
//  ---------+----------------------------------+-------------------------------------
//  Command  | start, busy (taken: start & !busy) | cmd, row, col, in_red/green/blue
//  Result   | out_valid (one-cycle strobe)     | out_row, out_col, out_red/green/blue
//  Config   | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// Busy stays low during a pixel write. A request runs two serial divisions for the axis
// ratios, sixteen pixel store reads and fifteen cubic evaluations on the shared
// multiplier. Reset is synchronous and clears the control state and sets the
// registers to 256; the pixel store is not cleared. The result strobe cannot be
// stalled by the receiver.
`timescale 1ns / 1ps

module bicubic_image_scaler_top (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [11:0] row,
  input  logic [11:0] col,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  // result channel
  output logic        out_valid,
  output logic [11:0] out_row,
  output logic [11:0] out_col,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned ACC = bis_pkg::ACC_BITS;

  // Configuration registers.
  logic [8:0]  src_height, src_width;
  logic [11:0] dst_height, dst_width;
  logic        cfg_wr;
  bis_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = bis_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_height <= 9'd256;
      src_width  <= 9'd256;
      dst_height <= 12'd256;
      dst_width  <= 12'd256;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bis_pkg::REG_SRC_HEIGHT: src_height <= pwdata[8:0];
        bis_pkg::REG_SRC_WIDTH:  src_width  <= pwdata[8:0];
        bis_pkg::REG_DST_HEIGHT: dst_height <= pwdata[11:0];
        bis_pkg::REG_DST_WIDTH:  dst_width  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bis_pkg::REG_SRC_HEIGHT: prdata = {23'd0, src_height};
      bis_pkg::REG_SRC_WIDTH:  prdata = {23'd0, src_width};
      bis_pkg::REG_DST_HEIGHT: prdata = {20'd0, dst_height};
      bis_pkg::REG_DST_WIDTH:  prdata = {20'd0, dst_width};
      default:                 prdata = '0;
    endcase
  end

  // Effective sizes: zero reads as one, sources saturate at the store size.
  logic [8:0]  sh, sw;
  logic [11:0] dh, dw;
  assign sh = (src_height == 9'd0) ? 9'd1 :
              (src_height > 9'(bis_pkg::MAX_SRC_HEIGHT)) ? 9'(bis_pkg::MAX_SRC_HEIGHT)
                                                         : src_height;
  assign sw = (src_width == 9'd0) ? 9'd1 :
              (src_width > 9'(bis_pkg::MAX_SRC_WIDTH)) ? 9'(bis_pkg::MAX_SRC_WIDTH)
                                                       : src_width;
  assign dh = (dst_height == 12'd0) ? 12'd1 : dst_height;
  assign dw = (dst_width == 12'd0) ? 12'd1 : dst_width;

  // Sequencer registers.
  bis_pkg::state_t state, state_next;
  logic        axis;
  logic [11:0] row_r, col_r;
  logic [bis_pkg::DVD_BITS-1:0] ratio;
  logic [36:0] prod_d, prod_c;
  logic [bis_pkg::BASE_BITS-1:0] base_y, base_x;
  logic [15:0] t_y, t_x;
  logic [4:0]  cnt;
  logic        rd_pend;
  logic [3:0]  rd_idx;
  logic [bis_pkg::PIX_BITS-1:0] pix [16];
  logic [2:0]  pass;
  logic [1:0]  ch;
  logic signed [ACC-1:0] colv [4];

  // Per-axis operands.
  logic [8:0]  s_ax;
  logic [11:0] d_ax, coord;
  logic [8:0]  num;
  assign s_ax  = axis ? sw : sh;
  assign d_ax  = axis ? dw : dh;
  assign coord = axis ? col_r : row_r;
  assign num   = (d_ax > {3'd0, s_ax}) ? (s_ax - 9'd1) : s_ax;

  // Serial divider for the ratio.
  logic div_start, div_done;
  logic [bis_pkg::DVD_BITS-1:0] div_q;
  assign div_start = (state == bis_pkg::ST_DIV_GO);

  bis_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({num[8:0], 16'd0}),
    .divisor  (d_ax),
    .done     (div_done),
    .quotient (div_q)
  );

  // Centring offset and source position.
  logic signed [38:0] diff;
  logic [23:0] offs;
  logic [37:0] pos;
  logic [7:0]  sm1;
  assign sm1  = 8'(s_ax - 9'd1);
  assign diff = $signed({15'd0, sm1, 16'd0}) - $signed({2'd0, prod_d});
  assign offs = (diff > 0) ? diff[24:1] : 24'd0;
  assign pos  = {1'b0, prod_c} + {14'd0, offs};

  // Pixel store port: writes from idle, reads while fetching.
  logic wr_en;
  logic [bis_pkg::ADDR_BITS-1:0] st_addr;
  logic [bis_pkg::PIX_BITS-1:0]  st_rdata;
  logic [7:0] nb_row, nb_col;
  assign wr_en = (state == bis_pkg::ST_IDLE) && start && (cmd == bis_pkg::CMD_WRITE) &&
                 (row < 12'(bis_pkg::MAX_SRC_HEIGHT)) && (col < 12'(bis_pkg::MAX_SRC_WIDTH));
  assign nb_row  = bis_pkg::border(base_y, cnt[3:2], sh);
  assign nb_col  = bis_pkg::border(base_x, cnt[1:0], sw);
  assign st_addr = wr_en ? {row[bis_pkg::ROW_BITS-1:0], col[bis_pkg::COL_BITS-1:0]}
                         : {nb_row[bis_pkg::ROW_BITS-1:0], nb_col[bis_pkg::COL_BITS-1:0]};

  bis_store u_store (
    .clk   (clk),
    .we    (wr_en),
    .addr  (st_addr),
    .wdata ({in_red, in_green, in_blue}),
    .rdata (st_rdata)
  );

  // Cubic unit operands: a row of the neighbourhood, or the column of row results.
  logic cub_start, cub_done;
  logic signed [ACC-1:0] cub_f [4];
  logic signed [ACC-1:0] cub_res;
  logic [15:0] cub_t;
  assign cub_start = (state == bis_pkg::ST_CUB_GO);
  assign cub_t     = (pass == 3'd4) ? t_y : t_x;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic [bis_pkg::PIX_BITS-1:0] p;
      logic [7:0] c8;
      p = pix[{pass[1:0], 2'(j)}];
      unique case (ch)
        2'd0:    c8 = p[23:16];
        2'd1:    c8 = p[15:8];
        default: c8 = p[7:0];
      endcase
      cub_f[j] = (pass == 3'd4) ? colv[j] : $signed({12'd0, c8, 16'd0});
    end
  end

  bis_cubic u_cubic (
    .clk   (clk),
    .rst   (rst),
    .start (cub_start),
    .f     (cub_f),
    .t     (cub_t),
    .done  (cub_done),
    .res   (cub_res)
  );

  // Rounding of the cubic result for either pass.
  logic signed [63:0] rnd_row, rnd_col;
  logic [7:0] chan_val;
  assign rnd_row  = bis_pkg::rne(64'(cub_res), 5'd1);
  assign rnd_col  = bis_pkg::rne(64'(cub_res), 5'd17);
  assign chan_val = (rnd_col < 0) ? 8'd0 : (rnd_col > 64'sd255) ? 8'd255 : rnd_col[7:0];

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bis_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and busy.
  always_comb begin
    state_next = state;
    busy       = (state != bis_pkg::ST_IDLE);
    unique case (state)
      bis_pkg::ST_IDLE:
        if (start && (cmd == bis_pkg::CMD_REQUEST)) state_next = bis_pkg::ST_DIV_GO;
      bis_pkg::ST_DIV_GO:   state_next = bis_pkg::ST_DIV_WAIT;
      bis_pkg::ST_DIV_WAIT: if (div_done) state_next = bis_pkg::ST_MUL;
      bis_pkg::ST_MUL:      state_next = bis_pkg::ST_POS;
      bis_pkg::ST_POS:      state_next = axis ? bis_pkg::ST_FETCH : bis_pkg::ST_DIV_GO;
      bis_pkg::ST_FETCH:    if (cnt == 5'd16) state_next = bis_pkg::ST_CUB_GO;
      bis_pkg::ST_CUB_GO:   state_next = bis_pkg::ST_CUB_WAIT;
      bis_pkg::ST_CUB_WAIT:
        if (cub_done) begin
          state_next = ((pass == 3'd4) && (ch == 2'd2)) ? bis_pkg::ST_IDLE
                                                        : bis_pkg::ST_CUB_GO;
        end
      default: state_next = bis_pkg::ST_IDLE;
    endcase
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      axis      <= 1'b0;
      cnt       <= '0;
      pass      <= '0;
      ch        <= '0;
    end else begin
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      // Read data lands in the cycle after its address.
      if (rd_pend) begin
        pix[rd_idx] <= st_rdata;
      end
      unique case (state)
        bis_pkg::ST_IDLE: begin
          if (start && (cmd == bis_pkg::CMD_REQUEST)) begin
            row_r <= row;
            col_r <= col;
            axis  <= 1'b0;
          end
        end
        bis_pkg::ST_DIV_WAIT: begin
          if (div_done) begin
            ratio <= div_q;
          end
        end
        bis_pkg::ST_MUL: begin
          prod_d <= {25'd0, d_ax - 12'd1} * {12'd0, ratio};
          prod_c <= {25'd0, coord} * {12'd0, ratio};
        end
        bis_pkg::ST_POS: begin
          if (axis) begin
            base_x <= pos[37:16];
            t_x    <= pos[15:0];
            cnt    <= '0;
          end else begin
            base_y <= pos[37:16];
            t_y    <= pos[15:0];
            axis   <= 1'b1;
          end
        end
        bis_pkg::ST_FETCH: begin
          if (cnt != 5'd16) begin
            rd_pend <= 1'b1;
            rd_idx  <= cnt[3:0];
            cnt     <= cnt + 1'b1;
          end else begin
            pass <= '0;
            ch   <= '0;
          end
        end
        bis_pkg::ST_CUB_WAIT: begin
          if (cub_done) begin
            if (pass != 3'd4) begin
              colv[pass[1:0]] <= rnd_row[ACC-1:0];
              pass <= pass + 1'b1;
            end else begin
              pass <= '0;
              unique case (ch)
                2'd0:    out_red   <= chan_val;
                2'd1:    out_green <= chan_val;
                default: out_blue  <= chan_val;
              endcase
              if (ch == 2'd2) begin
                out_valid <= 1'b1;
                out_row   <= row_r;
                out_col   <= col_r;
              end else begin
                ch <= ch + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
